[rtl/glyph_marker_scanner_macros.svh]
// assertion helpers shared by the scanner modules
`ifndef GLYPH_MARKER_SCANNER_MACROS_SVH
`define GLYPH_MARKER_SCANNER_MACROS_SVH

// property checked on every clock edge outside reset
`define GMS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define GMS_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

`endif

[rtl/gms_pkg.sv]
`timescale 1ns / 1ps

package gms_pkg;

   localparam int MAX_GLYPHS = 256;
   localparam int POS_W      = 12;
   localparam int SIZE_W     = 13;
   localparam int COUNT_W    = 9;
   localparam int INDEX_W    = 8;
   localparam int CSR_IDX_W  = 4;

   localparam logic [31:0] MARKER_PIXEL = 32'h0000_FF00;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic [1:0] KIND_ENTRY    = 2'd0;
   localparam logic [1:0] KIND_DONE     = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0] last_col;
      logic [POS_W-1:0] last_row;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [INDEX_W-1:0] glyph_index;
      logic [SIZE_W-1:0]  glyph_width;
      logic [POS_W-1:0]   glyph_left;
      logic [POS_W-1:0]   glyph_top;
      logic [POS_W-1:0]   tallest_band;
      logic [COUNT_W-1:0] glyph_total;
      logic               last;
   } result_type;

   // results pushed in one cycle, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

[rtl/gms_scan_core.sv]
`timescale 1ns / 1ps

module gms_scan_core (
   input  logic               clock,
   input  logic               reset,
   input  gms_pkg::cfg_type   cfg,
   input  logic               accept,
   input  logic [31:0]        pixel,
   output gms_pkg::push_type  push
);
   import gms_pkg::*;

   logic [POS_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic [POS_W-1:0]   left_ff, left_in;
   logic [POS_W-1:0]   band_ff, band_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]   hmax_ff, hmax_in;
   logic               had_ff, had_in;
   logic               ovf_ff, ovf_in;

   logic               marker, row_end, img_end, ovf_now, done;
   logic [POS_W-1:0]   band_h, hmax_upd;
   logic [COUNT_W-1:0] cnt_inc, count_upd;
   result_type         entry_res, err_res, done_res;

   always_comb begin
      marker   = !ovf_ff && (pixel == MARKER_PIXEL);
      row_end  = col_ff >= cfg.last_col;
      img_end  = row_end && (row_ff >= cfg.last_row);
      band_h   = row_ff - band_ff - POS_W'(1);
      hmax_upd = (marker && (row_ff > band_ff) && (band_h > hmax_ff)) ? band_h : hmax_ff;
      cnt_inc  = count_ff + COUNT_W'(1);
      count_upd = marker ? cnt_inc : count_ff;
      ovf_now  = marker && (cnt_inc >= COUNT_W'(MAX_GLYPHS));
      ovf_in   = ovf_ff || ovf_now;
      done     = img_end && !ovf_in;

      entry_res.kind         = KIND_ENTRY;
      entry_res.glyph_index  = count_ff[INDEX_W-1:0];
      entry_res.glyph_width  = {1'b0, col_ff} - {1'b0, left_ff} + SIZE_W'(1);
      entry_res.glyph_left   = left_ff;
      entry_res.glyph_top    = band_ff;
      entry_res.tallest_band = hmax_upd;
      entry_res.glyph_total  = '0;
      entry_res.last         = !(ovf_now || done);

      err_res              = '0;
      err_res.kind         = KIND_OVERFLOW;
      err_res.tallest_band = hmax_upd;
      err_res.glyph_total  = cnt_inc;
      err_res.last         = 1'b1;

      done_res              = '0;
      done_res.kind         = KIND_DONE;
      done_res.tallest_band = hmax_upd;
      done_res.glyph_total  = count_upd;
      done_res.last         = 1'b1;

      push.first  = done_res;
      push.second = ovf_now ? err_res : done_res;
      push.count  = 2'd0;
      if (marker) begin
         push.first = entry_res;
         push.count = (ovf_now || done) ? 2'd2 : 2'd1;
      end else if (done) begin
         push.count = 2'd1;
      end
      if (!accept) begin
         push.count = 2'd0;
      end

      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      band_in  = band_ff;
      count_in = count_ff;
      hmax_in  = hmax_ff;
      had_in   = had_ff;
      if (img_end) begin
         col_in   = '0;
         row_in   = '0;
         left_in  = '0;
         band_in  = '0;
         count_in = '0;
         hmax_in  = '0;
         had_in   = 1'b0;
         ovf_in   = 1'b0;
      end else if (row_end) begin
         if (had_ff || marker) begin
            band_in = row_ff + POS_W'(1);
         end
         had_in   = 1'b0;
         left_in  = '0;
         col_in   = '0;
         row_in   = row_ff + POS_W'(1);
         count_in = count_upd;
         hmax_in  = hmax_upd;
      end else begin
         col_in   = col_ff + POS_W'(1);
         if (marker) begin
            left_in = col_ff + POS_W'(1);
         end
         had_in   = had_ff || marker;
         count_in = count_upd;
         hmax_in  = hmax_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         band_ff  <= '0;
         count_ff <= '0;
         hmax_ff  <= '0;
         had_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
         band_ff  <= band_in;
         count_ff <= count_in;
         hmax_ff  <= hmax_in;
         had_ff   <= had_in;
         ovf_ff   <= ovf_in;
      end
   end

`include "glyph_marker_scanner_macros.svh"

   `GMS_ASSERT_IMPLY(a_ovf_count, clock, reset, ovf_ff, count_ff == COUNT_W'(MAX_GLYPHS), "overflow flag without full glyph count")
   `GMS_ASSERT(a_left_le_col, clock, reset, left_ff <= col_ff, "glyph left edge beyond current column")
   `GMS_ASSERT(a_band_le_row, clock, reset, band_ff <= row_ff, "band top below current row")

endmodule

[rtl/gms_rsp_queue.sv]
`timescale 1ns / 1ps

module gms_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  gms_pkg::push_type    push,
   output logic                 space,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gms_pkg::result_type  head
);
   import gms_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type       q_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   always_comb begin
      // room for the largest burst one transaction can cause
      space     = count_ff <= CNT_W'(DEPTH - 2);
      rsp_valid = count_ff != '0;
      head      = q_ff[rd_ptr_ff];
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`include "glyph_marker_scanner_macros.svh"

   `GMS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "result queue count beyond depth")
   `GMS_ASSERT_IMPLY(a_push_fits, clock, reset, push.count != 2'd0, (CNT_W+1)'(count_ff) + (CNT_W+1)'(push.count) <= (CNT_W+1)'(DEPTH), "result push into a full queue")
   `GMS_ASSERT(a_pointer_gap, clock, reset, wr_ptr_ff == rd_ptr_ff + PTR_W'(count_ff), "queue pointers disagree with count")

endmodule

[rtl/glyph_marker_scanner.sv]
`timescale 1ns / 1ps
// results: the results of a pixel are registered into the result queue and offered from its head in order
// throughput: one pixel per cycle while the result queue holds at most two results;
// a pixel causes up to two results, drained one per cycle while rsp_ready is high on the result side
// reset: scan position, counters and flags cleared, image size back to 256 by 256,
// result queue emptied; the configuration port is always ready
module glyph_marker_scanner (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [31:0]                    req_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_kind,
   output logic [gms_pkg::INDEX_W-1:0]    rsp_glyph_index,
   output logic [gms_pkg::SIZE_W-1:0]     rsp_glyph_width,
   output logic [gms_pkg::POS_W-1:0]      rsp_glyph_left,
   output logic [gms_pkg::POS_W-1:0]      rsp_glyph_top,
   output logic [gms_pkg::POS_W-1:0]      rsp_tallest_band,
   output logic [gms_pkg::COUNT_W-1:0]    rsp_glyph_total,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gms_pkg::SIZE_W-1:0]     csr_data
);
   import gms_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic [POS_W-1:0] last_pos;
   logic             accept;
   logic             space;
   push_type         push;
   result_type       head;

   // size register kept as last column / row index, zero read as one, clamped at 4096
   always_comb begin
      if (csr_data == '0) begin
         last_pos = '0;
      end else if (csr_data > SIZE_W'(4096)) begin
         last_pos = '1;
      end else begin
         last_pos = POS_W'(csr_data - SIZE_W'(1));
      end
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.last_col = last_pos;
            CSR_IMAGE_HEIGHT: cfg_in.last_row = last_pos;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.last_col <= POS_W'(255);
         cfg_ff.last_row <= POS_W'(255);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = space;
   assign accept    = req_valid && req_ready;

   gms_scan_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .pixel  (req_pixel),
      .push   (push)
   );

   gms_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_glyph_index  = head.glyph_index;
   assign rsp_glyph_width  = head.glyph_width;
   assign rsp_glyph_left   = head.glyph_left;
   assign rsp_glyph_top    = head.glyph_top;
   assign rsp_tallest_band = head.tallest_band;
   assign rsp_glyph_total  = head.glyph_total;
   assign rsp_last         = head.last;

endmodule

[bench/glyph_check_pkg.sv]
`timescale 1ns / 1ps

package glyph_check_pkg;
   import gms_pkg::*;

   class glyph_scoreboard;
      bit [SIZE_W-1:0]  width_reg;
      bit [SIZE_W-1:0]  height_reg;
      bit [POS_W-1:0]   col;
      bit [POS_W-1:0]   row;
      bit [POS_W-1:0]   left_edge;
      bit [POS_W-1:0]   band_top;
      bit [COUNT_W-1:0] found;
      bit [POS_W-1:0]   tallest;
      bit               row_marked;
      bit               saturated;
      result_type       glyphs_due[$];
      int               mismatches;

      function new();
         width_reg  = 256;
         height_reg = 256;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         col        = '0;
         row        = '0;
         left_edge  = '0;
         band_top   = '0;
         found      = '0;
         tallest    = '0;
         row_marked = 1'b0;
         saturated  = 1'b0;
      endfunction

      // zero reads as one, anything past the atlas limit as the limit
      function int unsigned span(bit [SIZE_W-1:0] v);
         if (v == 0) return 1;
         if (v > (1 << POS_W)) return 1 << POS_W;
         return v;
      endfunction

      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [SIZE_W-1:0] data);
         if (idx == CSR_IMAGE_WIDTH) width_reg = data;
         else if (idx == CSR_IMAGE_HEIGHT) height_reg = data;
      endfunction

      function void queue_result(logic [1:0] kind, logic [INDEX_W-1:0] idx,
                                 logic [SIZE_W-1:0] w, logic [POS_W-1:0] left,
                                 logic [POS_W-1:0] top, logic [COUNT_W-1:0] total);
         result_type r;
         r              = '0;
         r.kind         = kind;
         r.glyph_index  = idx;
         r.glyph_width  = w;
         r.glyph_left   = left;
         r.glyph_top    = top;
         r.tallest_band = tallest;
         r.glyph_total  = total;
         glyphs_due.push_back(r);
      endfunction

      function void note_pixel(bit [31:0] pix);
         int unsigned last_col;
         int unsigned last_row;
         int unsigned h;
         bit          row_end;
         bit          img_end;
         int          queued;
         result_type  tail;
         last_col = span(width_reg) - 1;
         last_row = span(height_reg) - 1;
         row_end  = col >= last_col;
         img_end  = row_end && row >= last_row;
         queued   = glyphs_due.size();

         if (!saturated && pix == MARKER_PIXEL) begin
            row_marked = 1'b1;
            if (row > band_top) begin
               h = row - band_top - 1;
               if (h > tallest) tallest = POS_W'(h);
            end
            queue_result(KIND_ENTRY, found[INDEX_W-1:0], SIZE_W'(col - left_edge + 1),
                         left_edge, band_top, '0);
            left_edge = POS_W'(col + 1);
            found     = found + 1'b1;
            if (found >= MAX_GLYPHS) begin
               saturated = 1'b1;
               queue_result(KIND_OVERFLOW, '0, '0, '0, '0, found);
            end
         end

         if (img_end) begin
            if (!saturated) queue_result(KIND_DONE, '0, '0, '0, '0, found);
            restart();
         end else if (row_end) begin
            if (row_marked) band_top = POS_W'(row + 1);
            row_marked = 1'b0;
            left_edge  = '0;
            col        = '0;
            row        = POS_W'(row + 1);
         end else begin
            col = POS_W'(col + 1);
         end

         if (glyphs_due.size() > queued) begin
            tail      = glyphs_due.pop_back();
            tail.last = 1'b1;
            glyphs_due.push_back(tail);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (glyphs_due.size() == 0) begin
            $error("result with nothing outstanding: kind %0d", got.kind);
            mismatches++;
            return;
         end
         want = glyphs_due.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("glyph_index", want.glyph_index, got.glyph_index);
         compare_field("glyph_width", want.glyph_width, got.glyph_width);
         compare_field("glyph_left", want.glyph_left, got.glyph_left);
         compare_field("glyph_top", want.glyph_top, got.glyph_top);
         compare_field("tallest_band", want.tallest_band, got.tallest_band);
         compare_field("glyph_total", want.glyph_total, got.glyph_total);
         compare_field("last", want.last, got.last);
      endfunction

      function int pending();
         return glyphs_due.size();
      endfunction
   endclass

endpackage

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
   import gms_pkg::*;
   import glyph_check_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_PIXELS = 100;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [31:0]          req_pixel = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_kind;
   logic [INDEX_W-1:0]   rsp_glyph_index;
   logic [SIZE_W-1:0]    rsp_glyph_width;
   logic [POS_W-1:0]     rsp_glyph_left;
   logic [POS_W-1:0]     rsp_glyph_top;
   logic [POS_W-1:0]     rsp_tallest_band;
   logic [COUNT_W-1:0]   rsp_glyph_total;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_data  = '0;

   glyph_scoreboard board;
   bit              calm;
   int              stall_left;

   always #2 clock = ~clock;

   glyph_marker_scanner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_glyph_index  (rsp_glyph_index),
      .rsp_glyph_width  (rsp_glyph_width),
      .rsp_glyph_left   (rsp_glyph_left),
      .rsp_glyph_top    (rsp_glyph_top),
      .rsp_tallest_band (rsp_tallest_band),
      .rsp_glyph_total  (rsp_glyph_total),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // receiver drops rsp_ready at random in bursts unless calm is set
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.kind         = rsp_kind;
         seen.glyph_index  = rsp_glyph_index;
         seen.glyph_width  = rsp_glyph_width;
         seen.glyph_left   = rsp_glyph_left;
         seen.glyph_top    = rsp_glyph_top;
         seen.tallest_band = rsp_tallest_band;
         seen.glyph_total  = rsp_glyph_total;
         seen.last         = rsp_last;
         board.check_result(seen);
      end
   end

   task automatic send_pixel(input logic [31:0] pix);
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(pix);
   endtask

   // close the input side and wait out every outstanding result
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      settle();
      set_reg(CSR_IMAGE_WIDTH, w);
      set_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   // markers, near misses one bit away, and plain noise
   function automatic logic [31:0] random_pixel(int unsigned marker_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < marker_pct) return MARKER_PIXEL;
      if (roll < marker_pct + 15) return MARKER_PIXEL ^ (32'd1 << $urandom_range(0, 31));
      return $urandom;
   endfunction

   task automatic send_plain(input int unsigned n);
      repeat (n) send_pixel(random_pixel(0));
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("glyph_marker_scanner test failed");
      $finish;
   end

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned sent;
      int          phase;
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // small atlas: one glyph in the top band, two in a taller band below
      set_size(3, 4);
      send_pixel(32'h0000_0000);
      send_pixel(MARKER_PIXEL);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(MARKER_PIXEL ^ 32'h0000_0001);
      send_pixel(MARKER_PIXEL ^ 32'h0100_0000);
      send_pixel(32'h0000_FE00);
      send_pixel(32'h8000_FF00);
      send_pixel(32'h0000_0000);
      send_pixel(32'h7FFF_FFFF);
      send_pixel(MARKER_PIXEL);
      send_pixel(32'h00FF_00FF);
      send_pixel(MARKER_PIXEL);

      // zero sizes act as one pixel; unmapped index is ignored
      set_size(0, 0);
      send_pixel(MARKER_PIXEL);
      send_pixel(32'h1234_5678);
      settle();
      set_reg(CSR_IMAGE_HEIGHT + 1, SIZE_W'(5));

      // width shrunk part way along a row
      set_size(8, 2);
      send_plain(5);
      settle();
      set_reg(CSR_IMAGE_WIDTH, 2);
      send_pixel(MARKER_PIXEL);
      send_pixel(32'h0000_0000);
      send_pixel(MARKER_PIXEL);

      // glyph limit reached, then the rest of the image is ignored
      set_size(16, 17);
      repeat (MAX_GLYPHS) send_pixel(MARKER_PIXEL);
      repeat (16) send_pixel(random_pixel(50));
      set_size(2, 1);
      send_pixel(MARKER_PIXEL);
      send_pixel(MARKER_PIXEL);

      // width written past the limit, scan left part way along the row
      set_size({SIZE_W{1'b1}}, 2);
      send_plain(3);
      send_pixel(MARKER_PIXEL);

      sent = 0;
      for (phase = 0; sent < RANDOM_PIXELS; phase++) begin
         calm = (sent >= RANDOM_PIXELS * 3 / 4) || (phase % 6 == 5);
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 5);
         if ($urandom_range(0, 9) == 0) w = 0;
         if ($urandom_range(0, 9) == 0) h = 0;
         settle();
         if ($urandom_range(0, 5) == 0)
            set_reg(CSR_IDX_W'($urandom_range(CSR_IMAGE_HEIGHT + 1, (1 << CSR_IDX_W) - 1)),
                    SIZE_W'($urandom));
         set_reg(CSR_IMAGE_WIDTH, SIZE_W'(w));
         set_reg(CSR_IMAGE_HEIGHT, SIZE_W'(h));
         n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
         // a partial image leaves the next size write landing mid-scan
         if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
         repeat (n) send_pixel(random_pixel(30));
         sent += n;
      end

      calm = 1'b1;
      settle();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("glyph_marker_scanner test passed");
      else
         $display("glyph_marker_scanner test failed");
      $finish;
   end

endmodule

[glyph_marker_scanner.f]
+incdir+rtl
rtl/gms_pkg.sv
rtl/gms_scan_core.sv
rtl/gms_rsp_queue.sv
rtl/glyph_marker_scanner.sv
bench/glyph_check_pkg.sv
bench/tb.sv
